// ===== hdl/nmp_pkg.sv =====
// ---------------------------------------------------------------------------
// nmp_pkg
// Shared types and constants for the nearest marker pairing block.
// ---------------------------------------------------------------------------
package nmp_pkg;

  // Operation codes carried in the input tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Team colors
  localparam logic TEAM_BLUE   = 1'b0;
  localparam logic TEAM_YELLOW = 1'b1;

  // Result field widths, fixed by the stream format
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned DIST_W     = 21;
  localparam int unsigned COLOR_W    = 3;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Scan sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SQX,
    S_SQY,
    S_DONE
  } nmp_state_e;

  // One finished query result
  typedef struct packed {
    logic                  found;
    logic                  nearest_team;
    logic [SLOT_OUT_W-1:0] nearest_slot;
    logic [DIST_W-1:0]     distance_sq;
    logic                  is_own_team;
    logic [COLOR_W-1:0]    color_out;
  } nmp_result_t;

endpackage

// ===== hdl/nmp_table.sv =====
// ---------------------------------------------------------------------------
// nmp_table
// Marker table: coordinate memory with registered read, plus valid flops.
// ---------------------------------------------------------------------------
module nmp_table #(
  parameter int unsigned SLOTS_PER_TEAM = 16,
  parameter int unsigned COORD_BITS     = 10,
  parameter int unsigned IDX_W          = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic [COORD_BITS-1:0] wr_x_i,
  input  logic [COORD_BITS-1:0] wr_y_i,
  input  logic                  wr_valid_i,
  input  logic [IDX_W-1:0]      addr_i,
  input  logic                  rd_en_i,
  output logic                  chk_valid_o,
  output logic [COORD_BITS-1:0] rd_x_o,
  output logic [COORD_BITS-1:0] rd_y_o
);

  localparam int unsigned DEPTH = 2 * SLOTS_PER_TEAM;

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rd_q;
  logic [DEPTH-1:0]        valid_q;

  // Write coordinates; read them back registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_y_i, wr_x_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[addr_i];
    end
  end

  // Hold valid bits, cleared at reset so the table starts empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= wr_valid_i;
    end
  end

  assign chk_valid_o = valid_q[addr_i];
  assign rd_x_o      = rd_q[COORD_BITS-1:0];
  assign rd_y_o      = rd_q[2*COORD_BITS-1:COORD_BITS];

endmodule

// ===== hdl/nmp_sqdist.sv =====
// ---------------------------------------------------------------------------
// nmp_sqdist
// Shared squaring unit: absolute difference of two coordinates, squared.
// ---------------------------------------------------------------------------
module nmp_sqdist #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic [COORD_BITS-1:0]   a_i,
  input  logic [COORD_BITS-1:0]   b_i,
  output logic [2*COORD_BITS-1:0] sq_o
);

  logic [COORD_BITS-1:0]   diff;
  logic [2*COORD_BITS-1:0] diff_ext;

  // Take the magnitude, then square it
  always_comb begin
    diff     = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);
    diff_ext = (2*COORD_BITS)'(diff);
    sq_o     = diff_ext * diff_ext;
  end

endmodule

// ===== hdl/nmp_ctrl.sv =====
// ---------------------------------------------------------------------------
// nmp_ctrl
// Scan sequencer: walks blue then yellow slots, tracks the nearest marker.
// ---------------------------------------------------------------------------
module nmp_ctrl #(
  parameter int unsigned SLOTS_PER_TEAM = 16,
  parameter int unsigned COORD_BITS     = 10,
  parameter int unsigned IDX_W          = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [COORD_BITS-1:0]       qx_i,
  input  logic [COORD_BITS-1:0]       qy_i,
  input  logic [nmp_pkg::COLOR_W-1:0] color_i,
  input  logic                        own_team_i,
  input  logic                        chk_valid_i,
  input  logic [COORD_BITS-1:0]       rd_x_i,
  input  logic [COORD_BITS-1:0]       rd_y_i,
  input  logic [2*COORD_BITS-1:0]     sq_i,
  input  logic                        res_taken_i,
  output logic                        idle_o,
  output logic [IDX_W-1:0]            addr_o,
  output logic                        rd_en_o,
  output logic [COORD_BITS-1:0]       op_a_o,
  output logic [COORD_BITS-1:0]       op_b_o,
  output logic                        res_valid_o,
  output nmp_pkg::nmp_result_t        res_o
);

  import nmp_pkg::*;

  localparam int unsigned SLOT_W = (SLOTS_PER_TEAM > 1) ? $clog2(SLOTS_PER_TEAM) : 1;
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  nmp_state_e state_q, state_d;

  logic                  team_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  found_q;
  logic [SUM_W-1:0]      best_q;
  logic                  best_team_q;
  logic [SLOT_W-1:0]     best_slot_q;
  logic [SQ_W-1:0]       sqx_q;
  logic [COORD_BITS-1:0] qx_q;
  logic [COORD_BITS-1:0] qy_q;
  logic [COLOR_W-1:0]    color_q;

  logic             slot_last;
  logic             sel_y;
  logic [SUM_W-1:0] sum;
  logic             better;
  logic [DIST_W-1:0] dist_sat;

  assign slot_last = (slot_q == SLOT_W'(SLOTS_PER_TEAM - 1));
  assign addr_o    = team_q ? (IDX_W'(SLOTS_PER_TEAM) + IDX_W'(slot_q)) : IDX_W'(slot_q);
  assign sum       = SUM_W'(sqx_q) + SUM_W'(sq_i);
  assign better    = !found_q || (sum < best_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (chk_valid_i) begin
          state_d = S_SQX;
        end else if (team_q == TEAM_YELLOW) begin
          state_d = S_DONE;
        end
      end
      S_SQX: begin
        state_d = S_SQY;
      end
      S_SQY: begin
        if (slot_last && (team_q == TEAM_YELLOW)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_DONE: begin
        if (res_taken_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    idle_o      = 1'b0;
    rd_en_o     = 1'b0;
    sel_y       = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE:  idle_o      = 1'b1;
      S_CHECK: rd_en_o     = chk_valid_i;
      S_SQX:   sel_y       = 1'b0;
      S_SQY:   sel_y       = 1'b1;
      S_DONE:  res_valid_o = 1'b1;
      default: idle_o      = 1'b0;
    endcase
  end

  // Steer the shared squaring unit: x term first, then y term
  assign op_a_o = sel_y ? qy_q : qx_q;
  assign op_b_o = sel_y ? rd_y_i : rd_x_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the scan position and the found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      team_q  <= TEAM_BLUE;
      slot_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (state_q == S_IDLE && start_i) begin
        team_q  <= TEAM_BLUE;
        slot_q  <= '0;
        found_q <= 1'b0;
      end else if (state_q == S_CHECK && !chk_valid_i && team_q == TEAM_BLUE) begin
        team_q <= TEAM_YELLOW;
        slot_q <= '0;
      end else if (state_q == S_SQY) begin
        if (better) begin
          found_q <= 1'b1;
        end
        if (slot_last) begin
          if (team_q == TEAM_BLUE) begin
            team_q <= TEAM_YELLOW;
            slot_q <= '0;
          end
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

  // Hold query operands, partial square and best candidate
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      qx_q    <= qx_i;
      qy_q    <= qy_i;
      color_q <= color_i;
    end
    if (state_q == S_SQX) begin
      sqx_q <= sq_i;
    end
    if (state_q == S_SQY && better) begin
      best_q      <= sum;
      best_team_q <= team_q;
      best_slot_q <= slot_q;
    end
  end

  // Saturate the distance and build the result
  always_comb begin
    if (CMP_W'(best_q) > CMP_W'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = DIST_W'(best_q);
    end
    res_o.found        = found_q;
    res_o.nearest_team = found_q ? best_team_q : TEAM_BLUE;
    res_o.nearest_slot = found_q ? SLOT_OUT_W'(best_slot_q) : '0;
    res_o.distance_sq  = found_q ? dist_sat : '0;
    res_o.is_own_team  = found_q && (best_team_q == own_team_i);
    res_o.color_out    = color_q;
  end

endmodule

// ===== hdl/nearest_marker_pairing_top.sv =====
// ---------------------------------------------------------------------------
// nearest_marker_pairing_top
// Nearest team marker search by squared distance over a two-color table.
// ---------------------------------------------------------------------------
// Write requests give no result.
// A query scans each color's slots in order up to that color's first invalid slot;
//   each valid slot is checked, then its x and y terms are squared and summed.
// One query at a time, the input reopens in the cycle after the result is loaded;
//   a full, stalled output register holds both. One squaring unit, x term then y term.
// Reset clears the valid bits (empty table), own_team and all control state.
module nearest_marker_pairing_top #(
  parameter int unsigned SLOTS_PER_TEAM = 16,
  parameter int unsigned COORD_BITS     = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write: own_team
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: team_select[0], slot[4:1], entry_valid[5], pos_x[15:6],
  //        pos_y[25:16], secondary_color[28:26], zero fill [31:29]
  input  logic [31:0] s_axis_tdata,
  // tuser: operation[0]
  input  logic        s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: found[0], nearest_team[1], nearest_slot[5:2], distance_sq[26:6],
  //        is_own_team[27], color_out[30:28], zero fill [31]
  output logic [31:0] m_axis_tdata
);

  import nmp_pkg::*;

  localparam int unsigned IDX_W = $clog2(2 * SLOTS_PER_TEAM);

  logic                  in_accept;
  logic                  in_team;
  logic [3:0]            in_slot;
  logic                  in_valid_bit;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic [COLOR_W-1:0]    in_color;

  logic                  own_team_q;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic                  start;

  logic                  idle;
  logic [IDX_W-1:0]      addr;
  logic                  rd_en;
  logic                  chk_valid;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  logic [COORD_BITS-1:0] op_a;
  logic [COORD_BITS-1:0] op_b;
  logic [2*COORD_BITS-1:0] sq;
  logic                  res_valid;
  logic                  res_taken;
  nmp_result_t           res;

  logic                  m_valid_q;
  logic [31:0]           m_data_q;

  // Unpack the request
  assign in_team      = s_axis_tdata[0];
  assign in_slot      = s_axis_tdata[4:1];
  assign in_valid_bit = s_axis_tdata[5];
  assign in_x         = COORD_BITS'(s_axis_tdata[15:6]);
  assign in_y         = COORD_BITS'(s_axis_tdata[25:16]);
  assign in_color     = s_axis_tdata[28:26];

  assign s_axis_tready = idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Drop writes to slots beyond the table
  assign wr_en   = in_accept && (s_axis_tuser == OP_WRITE)
                   && (32'(in_slot) < SLOTS_PER_TEAM);
  assign wr_addr = (in_team == TEAM_YELLOW) ? (IDX_W'(SLOTS_PER_TEAM) + IDX_W'(in_slot))
                                            : IDX_W'(in_slot);
  assign start   = in_accept && (s_axis_tuser == OP_QUERY);

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_team_q <= TEAM_BLUE;
    end else if (cfg_valid_i) begin
      own_team_q <= cfg_data_i;
    end
  end

  nmp_table #(
    .SLOTS_PER_TEAM (SLOTS_PER_TEAM),
    .COORD_BITS     (COORD_BITS),
    .IDX_W          (IDX_W)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_x_i      (in_x),
    .wr_y_i      (in_y),
    .wr_valid_i  (in_valid_bit),
    .addr_i      (addr),
    .rd_en_i     (rd_en),
    .chk_valid_o (chk_valid),
    .rd_x_o      (rd_x),
    .rd_y_o      (rd_y)
  );

  nmp_sqdist #(
    .COORD_BITS (COORD_BITS)
  ) u_sqdist (
    .a_i  (op_a),
    .b_i  (op_b),
    .sq_o (sq)
  );

  nmp_ctrl #(
    .SLOTS_PER_TEAM (SLOTS_PER_TEAM),
    .COORD_BITS     (COORD_BITS),
    .IDX_W          (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .qx_i        (in_x),
    .qy_i        (in_y),
    .color_i     (in_color),
    .own_team_i  (own_team_q),
    .chk_valid_i (chk_valid),
    .rd_x_i      (rd_x),
    .rd_y_i      (rd_y),
    .sq_i        (sq),
    .res_taken_i (res_taken),
    .idle_o      (idle),
    .addr_o      (addr),
    .rd_en_o     (rd_en),
    .op_a_o      (op_a),
    .op_b_o      (op_b),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load the output register when it is empty or being drained
  assign res_taken = res_valid && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_taken) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      m_data_q <= {1'b0, res.color_out, res.is_own_team, res.distance_sq,
                   res.nearest_slot, res.nearest_team, res.found};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
